// ===== rtl/upd_pkg.sv =====
package upd_pkg;

    // character codes
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // escape progress
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    // one raw input transaction
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_in;
    } t_in_item;

    // one decoded output transaction
    typedef struct packed {
        logic [7:0] byte_out;
        logic       error;
        logic       last_out;
    } t_out_item;

    // decoder state carried from byte to byte
    typedef struct packed {
        t_phase     phase;
        logic [3:0] high_nibble;
        logic       discarding;
    } t_dec_state;

    // hex digit value in the low bits, bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h41 + 8'd10;
            return {1'b1, v[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h61 + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    // plus always leaves as space
    function automatic logic [7:0] map_plus(input logic [7:0] b);
        return (b == PLUS_CHAR) ? SPACE_CHAR : b;
    endfunction

endpackage

// ===== rtl/url_percent_decoder_unit.sv =====
// an accepted input transaction is held in the input register, and its result in the result register
// throughput: one byte per cycle while i_out_stall is low, set by the single input register and result register
// a new byte is taken while a finished result still waits for the far side, but only into an empty input register
// reset: synchronous active low, clears both valid flags and the escape state
module url_percent_decoder_unit
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    t_dec_state r_state;
    t_dec_state n_state;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       w_res_valid;
    t_out_item  w_res;
    logic       w_out_free;
    logic       w_fire;
    logic       w_in_ready;

    // handshake between the stages
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign w_in_ready = !r_in_valid || w_fire;
    assign o_in_stall = !w_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (w_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // decode logic for the registered byte
    upd_step u_step (
        .i_item      (r_in_item),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, high_nibble: 4'd0, discarding: 1'b0};
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && w_res_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/upd_step.sv =====
module upd_step
    import upd_pkg::*;
(
    input  t_in_item   i_item,
    input  t_dec_state i_state,
    output t_dec_state o_state,
    output logic       o_res_valid,
    output t_out_item  o_res
);

    logic [4:0] w_hex;
    logic       w_last;

    assign w_hex  = hex_digit(i_item.byte_in);
    assign w_last = i_item.last_in;

    // next state and result for one byte
    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_state.discarding) begin
            // drop the rest of a failed string
            if (w_last) begin
                o_state.discarding = 1'b0;
            end
        end else begin
            case (i_state.phase)
                PH_FIRST: begin
                    if (!w_hex[4] || w_last) begin
                        o_state.phase       = PH_IDLE;
                        o_state.high_nibble = 4'd0;
                        o_state.discarding  = !w_last;
                        o_res_valid         = 1'b1;
                        o_res               = '{byte_out: 8'd0, error: 1'b1, last_out: 1'b1};
                    end else begin
                        o_state.high_nibble = w_hex[3:0];
                        o_state.phase       = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    o_state.phase       = PH_IDLE;
                    o_state.high_nibble = 4'd0;
                    o_res_valid         = 1'b1;
                    if (!w_hex[4]) begin
                        o_state.discarding = !w_last;
                        o_res = '{byte_out: 8'd0, error: 1'b1, last_out: 1'b1};
                    end else begin
                        o_res = '{byte_out: map_plus({i_state.high_nibble, w_hex[3:0]}),
                                  error: 1'b0, last_out: w_last};
                    end
                end
                default: begin
                    // outside an escape, the unused phase code included
                    o_state.phase = PH_IDLE;
                    if (i_item.byte_in == PCT_CHAR) begin
                        if (w_last) begin
                            o_state.high_nibble = 4'd0;
                            o_res_valid         = 1'b1;
                            o_res = '{byte_out: 8'd0, error: 1'b1, last_out: 1'b1};
                        end else begin
                            o_state.phase = PH_FIRST;
                        end
                    end else begin
                        o_res_valid = 1'b1;
                        o_res = '{byte_out: map_plus(i_item.byte_in), error: 1'b0,
                                  last_out: w_last};
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/upd_checker.sv =====
module upd_checker
    import upd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // an error transaction carries a zero byte and ends the string
    a_error_form: assert property (@(posedge i_clk)
        (o_out_valid && o_out_item.error) |-> (o_out_item.byte_out == 8'd0 && o_out_item.last_out))
        else $error("error result not zero or not last");

    // plus never leaves the decoder
    a_no_plus: assert property (@(posedge i_clk)
        o_out_valid |-> (o_out_item.byte_out != PLUS_CHAR))
        else $error("plus byte on output");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(o_out_valid && i_out_stall) && $past(i_rst_n))
            |-> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_in_valid && o_in_stall) && $past(i_rst_n))
            |-> (i_in_valid && $stable(i_in_item)))
        else $error("stalled input changed");

endmodule

bind url_percent_decoder_unit upd_checker u_checker (.*);

// ===== dv/url_percent_decoder_unit_test.sv =====
module url_percent_decoder_unit_test;
    import upd_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    // how a directed row gets its expected result
    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_SILENT  = 2'd1,
        ROW_TYPED   = 2'd2
    } t_row_kind;

    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        t_row_kind  kind;
        t_out_item  want;
    } t_dir_row;

    localparam t_out_item ERROR_RESULT = '{byte_out: 8'h00, error: 1'b1, last_out: 1'b1};

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    // decoder state mirrored by the predictor
    t_phase     esc_phase;
    logic [3:0] esc_high;
    bit         dropping;

    t_out_item decoded_q[$];
    t_dir_row  dir_rows[$];

    int  n_sent;
    int  n_dropped;
    int  n_strings;
    int  n_escapes;
    int  n_checked;
    int  n_errors;
    int  n_mismatch;
    int  idle_edges;
    bit  no_idle;
    bit  hold_req;

    url_percent_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit idle_roll();
        return !no_idle && ($urandom_range(0, 99) < 23);
    endfunction

    // queue one expected result
    function automatic void add_expect(input t_out_item r);
        decoded_q = {decoded_q, r};
    endfunction

    // append one directed row
    function automatic void add_row(input t_dir_row row);
        dir_rows = {dir_rows, row};
    endfunction

    // value of a hex digit in either case
    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = c[3:0];
            return 1'b1;
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the mirrored decoder by one raw byte, 1 when a result is due
    function automatic bit decode_byte(input t_in_item it, output t_out_item res);
        logic [3:0] nib;
        logic [7:0] raw;
        bit         is_hex;
        bit         bad;
        res = '0;
        raw = it.byte_in;
        is_hex = hex_nibble(it.byte_in, nib);
        if (dropping) begin
            n_dropped++;
            if (it.last_in) dropping = 1'b0;
            return 1'b0;
        end
        case (esc_phase)
            PH_FIRST:  bad = !is_hex || it.last_in;
            PH_SECOND: bad = !is_hex;
            default:   bad = (it.byte_in == PCT_CHAR) && it.last_in;
        endcase
        // malformed or cut-off escape ends the string
        if (bad) begin
            esc_phase = PH_IDLE;
            esc_high = 4'd0;
            dropping = !it.last_in;
            res = ERROR_RESULT;
            return 1'b1;
        end
        case (esc_phase)
            PH_FIRST: begin
                esc_high = nib;
                esc_phase = PH_SECOND;
                return 1'b0;
            end
            PH_SECOND: begin
                raw = {esc_high, nib};
                esc_phase = PH_IDLE;
                esc_high = 4'd0;
                n_escapes++;
            end
            default: begin
                esc_phase = PH_IDLE;
                if (it.byte_in == PCT_CHAR) begin
                    esc_phase = PH_FIRST;
                    return 1'b0;
                end
            end
        endcase
        res.byte_out = (raw == PLUS_CHAR) ? SPACE_CHAR : raw;
        res.last_out = it.last_in;
        return 1'b1;
    endfunction

    // offer one input transaction and record what it should produce
    task automatic send_byte(input t_in_item it, input t_row_kind kind, input t_out_item want);
        t_out_item res;
        bit        has_res;
        @(negedge i_clk);
        while (idle_roll()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        if (it.last_in) n_strings++;
        has_res = decode_byte(it, res);
        if (kind == ROW_TYPED) add_expect(want);
        else if (kind == ROW_PREDICT && has_res) add_expect(res);
    endtask

    // sender pauses until every expected result is out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [3:0] v;
        c = 8'($urandom_range(0, 255));
        while (hex_nibble(c, v)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // one encoded string: mostly plain bytes and good escapes, some broken ones
    task automatic send_random_string();
        t_in_item seq[$];
        t_in_item it;
        int       n_seg;
        int       pick;
        n_seg = $urandom_range(1, 6);
        it = '0;
        for (int s = 0; s < n_seg; s++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                it.byte_in = 8'($urandom_range(0, 255));
                seq = {seq, it};
            end else if (pick < 55) begin
                it.byte_in = PLUS_CHAR;
                seq = {seq, it};
            end else if (pick < 88) begin
                it.byte_in = PCT_CHAR;
                seq = {seq, it};
                it.byte_in = rand_hex_char();
                seq = {seq, it};
                it.byte_in = rand_hex_char();
                seq = {seq, it};
            end else if (pick < 94) begin
                it.byte_in = PCT_CHAR;
                seq = {seq, it};
                if ($urandom_range(0, 1)) begin
                    it.byte_in = rand_hex_char();
                    seq = {seq, it};
                end
                it.byte_in = rand_non_hex();
                seq = {seq, it};
            end else begin
                // truncated escape closes the string
                it.byte_in = PCT_CHAR;
                seq = {seq, it};
                if ($urandom_range(0, 1)) begin
                    it.byte_in = rand_hex_char();
                    seq = {seq, it};
                end
                break;
            end
        end
        seq[seq.size() - 1].last_in = 1'b1;
        foreach (seq[k]) send_byte(seq[k], ROW_PREDICT, '0);
    endtask

    // random strings with a little raw noise between them
    task automatic send_random(input int count);
        t_in_item it;
        int       target;
        target = n_sent - n_dropped + count;
        while (n_sent - n_dropped < target) begin
            if ($urandom_range(0, 19) == 0) begin
                it.byte_in = 8'($urandom_range(0, 255));
                it.last_in = 1'($urandom_range(0, 1));
                send_byte(it, ROW_PREDICT, '0);
            end else begin
                send_random_string();
            end
        end
    endtask

    task automatic report(input string what, input t_out_item want, input t_out_item got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch %0d: %s exp byte=%02h err=%0b last=%0b got byte=%02h err=%0b last=%0b",
                     n_mismatch, what, want.byte_out, want.error, want.last_out,
                     got.byte_out, got.error, got.last_out);
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_stall <= idle_roll();
        end
    end

    // compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (o_out_item.error) n_errors++;
            if (decoded_q.size() == 0) begin
                report("unexpected result", '0, o_out_item);
            end else begin
                want = decoded_q.pop_front();
                if (o_out_item.byte_out !== want.byte_out || o_out_item.error !== want.error ||
                    o_out_item.last_out !== want.last_out)
                    report("wrong result", want, o_out_item);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        idle_edges = 0;
        while (idle_edges < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_edges = 0;
            else idle_edges++;
        end
        $display("timeout with %0d results outstanding", decoded_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        esc_phase  = PH_IDLE;
        esc_high   = 4'd0;
        dropping   = 1'b0;

        // directed strings: plain extremes, escapes, bad and cut-off escapes
        add_row('{8'h61, 1'b0, ROW_PREDICT, '0});
        add_row('{PLUS_CHAR, 1'b0, ROW_TYPED, {SPACE_CHAR, 1'b0, 1'b0}});
        add_row('{8'h00, 1'b0, ROW_TYPED, {8'h00, 1'b0, 1'b0}});
        add_row('{8'hFF, 1'b1, ROW_TYPED, {8'hFF, 1'b0, 1'b1}});
        add_row('{PCT_CHAR, 1'b0, ROW_SILENT, '0});
        add_row('{8'h32, 1'b0, ROW_SILENT, '0});
        add_row('{8'h62, 1'b0, ROW_TYPED, {SPACE_CHAR, 1'b0, 1'b0}});
        add_row('{PCT_CHAR, 1'b0, ROW_SILENT, '0});
        add_row('{8'h66, 1'b0, ROW_SILENT, '0});
        add_row('{8'h46, 1'b1, ROW_TYPED, {8'hFF, 1'b0, 1'b1}});
        add_row('{PCT_CHAR, 1'b0, ROW_SILENT, '0});
        add_row('{8'h30, 1'b0, ROW_SILENT, '0});
        add_row('{8'h30, 1'b0, ROW_TYPED, {8'h00, 1'b0, 1'b0}});
        add_row('{PCT_CHAR, 1'b0, ROW_SILENT, '0});
        add_row('{PCT_CHAR, 1'b0, ROW_TYPED, ERROR_RESULT});
        add_row('{PCT_CHAR, 1'b0, ROW_SILENT, '0});
        add_row('{PLUS_CHAR, 1'b1, ROW_SILENT, '0});
        add_row('{PCT_CHAR, 1'b1, ROW_TYPED, ERROR_RESULT});
        add_row('{PCT_CHAR, 1'b0, ROW_SILENT, '0});
        add_row('{8'h61, 1'b1, ROW_TYPED, ERROR_RESULT});
        add_row('{PCT_CHAR, 1'b0, ROW_SILENT, '0});
        add_row('{8'h41, 1'b0, ROW_SILENT, '0});
        add_row('{8'h2F, 1'b1, ROW_TYPED, ERROR_RESULT});
        add_row('{8'h37, 1'b1, ROW_PREDICT, '0});

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_byte('{byte_in: dir_rows[r].raw, last_in: dir_rows[r].last},
                      dir_rows[r].kind, dir_rows[r].want);
        drain_results();

        send_random(120);

        // long stretch with no idling on either side
        no_idle = 1'b1;
        send_random(100);
        no_idle = 1'b0;

        // receiver holds off while the sender keeps offering
        hold_req = 1'b1;
        send_random(40);
        drain_results();

        send_random(140);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d input transactions in %0d strings, %0d dropped after errors",
                 n_sent, n_strings, n_dropped);
        $display("%0d results checked, %0d escapes decoded, %0d error results",
                 n_checked, n_escapes, n_errors);
        if (n_mismatch == 0 && decoded_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", n_mismatch, decoded_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/upd_pkg.sv
rtl/upd_step.sv
rtl/url_percent_decoder_unit.sv
rtl/upd_checker.sv
dv/url_percent_decoder_unit_test.sv
